/* rtl/ttgm_pkg.sv */
`default_nettype none

package ttgm_pkg;

   // sizing
   localparam int MAX_TAPER   = 64;
   localparam int MAX_TRACE   = 4096;
   localparam int TIDX_W      = $clog2(MAX_TAPER);
   localparam int TLEN_W      = $clog2(MAX_TAPER + 1);
   localparam int NT_W        = $clog2(MAX_TRACE + 1);
   localparam int SIDX_W      = 12;
   localparam int SAMPLE_W    = 24;
   localparam int WEIGHT_W    = 17;
   localparam int FRAC_W      = 16;
   localparam int TIME_W      = 14;
   localparam int SHIFT_W     = 14;
   localparam int MODE_W      = 3;
   localparam int BND_W       = 18;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(1 << FRAC_W);

   // gate modes
   localparam logic [MODE_W-1:0] MODE_ABOVE      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_THETA      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_THETA_KEEP = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BELOW      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PSI        = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DIRECT     = 3'd5;

   // item commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // register indexes
   localparam logic [1:0] REG_GATE_MODE    = 2'd0;
   localparam logic [1:0] REG_TAPER_LENGTH = 2'd1;
   localparam logic [1:0] REG_TIME_SHIFT   = 2'd2;
   localparam logic [1:0] REG_TRACE_LENGTH = 2'd3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [WEIGHT_W-1:0]        weight_type;
   typedef logic signed [BND_W-1:0]    bnd_type;

   typedef struct packed {
      logic [MODE_W-1:0]         gate_mode;
      logic [TLEN_W-1:0]         taper_length;
      logic signed [SHIFT_W-1:0] time_shift;
      logic [NT_W-1:0]           trace_length;
   } cfg_type;

   typedef struct packed {
      logic                     cmd;
      logic [TIDX_W-1:0]        taper_index;
      weight_type               taper_value;
      sample_type               sample_value;
      logic [SIDX_W-1:0]        sample_index;
      logic signed [TIME_W-1:0] mute_time;
      logic signed [TIME_W-1:0] sync_time;
   } item_type;

   // classified beat between front and back
   typedef struct packed {
      logic              is_load;
      weight_type        weight;
      sample_type        value;
      logic [SIDX_W-1:0] index;
      logic              zero;
      logic              en_a;
      logic [TIDX_W-1:0] idx_a;
      logic              en_b;
      logic [TIDX_W-1:0] idx_b;
   } entry_type;

   // magnitude times weight, round half away from zero
   function automatic sample_type taper_scale(input sample_type v, input weight_type w);
      logic                neg;
      logic [SAMPLE_W-1:0] mag;
      logic [PROD_W-1:0]   prod;
      logic [SAMPLE_W-1:0] r;
      neg  = v[SAMPLE_W-1];
      mag  = neg ? SAMPLE_W'(-v) : SAMPLE_W'(v);
      prod = PROD_W'(mag) * PROD_W'(w) + PROD_W'(1 << (FRAC_W - 1));
      r    = prod[FRAC_W +: SAMPLE_W];
      return neg ? sample_type'(~r + 1'b1) : sample_type'(r);
   endfunction

endpackage

`default_nettype wire

/* rtl/ttgm_front.sv */
`default_nettype none

module ttgm_front (
   input  logic                clock,
   input  logic                reset,
   input  ttgm_pkg::cfg_type   cfg,
   input  logic                push,
   output logic                full,
   input  ttgm_pkg::item_type  req_item,
   output logic                q_push,
   output ttgm_pkg::entry_type q_entry,
   input  logic                q_full
);
   import ttgm_pkg::*;

   typedef struct packed {
      bnd_type x;
      bnd_type y;
      logic    zall;
   } base_type;

   typedef struct packed {
      bnd_type zl;
      bnd_type zh;
      bnd_type m0;
      bnd_type m1;
      bnd_type a0;
      bnd_type a1;
      bnd_type b0;
      bnd_type b1;
      logic    a_down;
      logic    b_down;
      logic    zall;
   } bound_type;

   localparam bnd_type ONE_B   = bnd_type'(1);
   localparam bnd_type BND_MAX = {1'b0, {(BND_W-1){1'b1}}};

   function automatic bnd_type max0(input bnd_type v);
      return v[BND_W-1] ? '0 : v;
   endfunction

   function automatic bnd_type min_nt(input bnd_type v, input bnd_type nt);
      return (v < nt) ? v : nt;
   endfunction

   logic      v0_ff, v1_ff, v2_ff;
   logic      rdy0, rdy1, rdy2;
   item_type  it0_ff, it1_ff, it2_ff;
   base_type  base1_ff, base1_in;
   bound_type bound2_ff, bound2_in;
   bnd_type   nt_b, mm;
   bnd_type   t_b, s_b, sh_b;
   bnd_type   xm, xp, ym, yp;
   bnd_type   jb, off_a, off_b, ia_full, ib_full;
   logic      keep;

   assign nt_b = bnd_type'(cfg.trace_length);
   assign mm   = bnd_type'(cfg.taper_length);

   assign rdy2 = !v2_ff || !q_full;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;
   assign full = !rdy0;

   // stage 0: take the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (rdy0) begin
         v0_ff <= push;
      end
      if (rdy0 && push) begin
         it0_ff <= req_item;
      end
   end

   // stage 1: mode-dependent base times
   always_comb begin
      t_b  = bnd_type'(it0_ff.mute_time);
      s_b  = bnd_type'(it0_ff.sync_time);
      sh_b = bnd_type'(cfg.time_shift);
      base1_in.x    = '0;
      base1_in.y    = '0;
      base1_in.zall = 1'b0;
      case (cfg.gate_mode)
         MODE_ABOVE: begin
            base1_in.x = t_b - (s_b <<< 1) - sh_b;
         end
         MODE_THETA: begin
            base1_in.x    = t_b - (s_b <<< 1) - sh_b;
            base1_in.y    = nt_b - t_b + sh_b;
            base1_in.zall = t_b >= bnd_type'(cfg.trace_length >> 1);
         end
         MODE_THETA_KEEP: begin
            base1_in.x    = t_b - (s_b <<< 1) + sh_b;
            base1_in.y    = nt_b - t_b - sh_b;
            base1_in.zall = t_b >= bnd_type'(cfg.trace_length >> 1);
         end
         MODE_BELOW: begin
            base1_in.x = s_b + t_b - sh_b;
         end
         MODE_PSI: begin
            base1_in.x = t_b - sh_b;
            base1_in.y = nt_b - t_b + sh_b;
         end
         MODE_DIRECT: begin
            base1_in.x = t_b - sh_b;
            base1_in.y = t_b + sh_b;
         end
         default: begin
            base1_in.x = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= v0_ff;
      end
      if (rdy1) begin
         it1_ff   <= it0_ff;
         base1_ff <= base1_in;
      end
   end

   // stage 2: interval bounds
   assign xm = base1_ff.x - mm;
   assign xp = base1_ff.x + mm;
   assign ym = base1_ff.y - mm;
   assign yp = base1_ff.y + mm;

   always_comb begin
      bound2_in.zl     = '0;
      bound2_in.zh     = BND_MAX;
      bound2_in.m0     = '0;
      bound2_in.m1     = '0;
      bound2_in.a0     = '0;
      bound2_in.a1     = '0;
      bound2_in.b0     = '0;
      bound2_in.b1     = '0;
      bound2_in.a_down = 1'b0;
      bound2_in.b_down = 1'b0;
      bound2_in.zall   = base1_ff.zall;
      case (cfg.gate_mode)
         MODE_ABOVE: begin
            bound2_in.zl     = max0(xm);
            bound2_in.a0     = max0(xm);
            bound2_in.a1     = max0(base1_ff.x);
            bound2_in.a_down = 1'b1;
         end
         MODE_THETA, MODE_THETA_KEEP: begin
            // the sample right after the first taper stays ungated
            bound2_in.a0     = max0(base1_ff.x);
            bound2_in.a1     = max0(xp);
            bound2_in.m0     = max0(xp) + ONE_B;
            bound2_in.m1     = min_nt(ym + ONE_B, nt_b);
            bound2_in.b0     = min_nt(ym, nt_b);
            bound2_in.b1     = min_nt(base1_ff.y, nt_b);
            bound2_in.b_down = 1'b1;
         end
         MODE_BELOW: begin
            bound2_in.a0 = max0(base1_ff.x);
            bound2_in.a1 = max0(xp);
            bound2_in.zh = max0(xp);
         end
         MODE_PSI: begin
            bound2_in.a0     = max0(xm);
            bound2_in.a1     = max0(base1_ff.x);
            bound2_in.a_down = 1'b1;
            bound2_in.zl     = max0(xm - ONE_B);
            bound2_in.zh     = min_nt(yp + ONE_B, nt_b);
            bound2_in.b0     = min_nt(base1_ff.y, nt_b);
            bound2_in.b1     = min_nt(yp, nt_b);
         end
         MODE_DIRECT: begin
            bound2_in.zl     = max0(xm);
            bound2_in.a0     = max0(xm);
            bound2_in.a1     = max0(base1_ff.x);
            bound2_in.a_down = 1'b1;
            bound2_in.b0     = max0(base1_ff.y);
            bound2_in.b1     = max0(yp);
            bound2_in.zh     = max0(yp);
         end
         default: begin
            bound2_in.zall = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
      if (rdy2) begin
         it2_ff    <= it1_ff;
         bound2_ff <= bound2_in;
      end
   end

   // classify against the sample index
   assign jb      = bnd_type'(it2_ff.sample_index);
   assign off_a   = jb - bound2_ff.a0;
   assign off_b   = jb - bound2_ff.b0;
   assign ia_full = bound2_ff.a_down ? (mm - ONE_B - off_a) : off_a;
   assign ib_full = bound2_ff.b_down ? (mm - ONE_B - off_b) : off_b;

   always_comb begin
      q_entry.is_load = (it2_ff.cmd == CMD_LOAD);
      q_entry.weight  = (it2_ff.taper_value > ONE_Q16) ? ONE_Q16 : it2_ff.taper_value;
      q_entry.value   = it2_ff.sample_value;
      q_entry.index   = it2_ff.sample_index;
      q_entry.zero    = bound2_ff.zall || (jb < bound2_ff.zl) || (jb >= bound2_ff.zh)
                        || ((jb >= bound2_ff.m0) && (jb < bound2_ff.m1));
      q_entry.en_a    = (jb >= bound2_ff.a0) && (jb < bound2_ff.a1);
      q_entry.idx_a   = q_entry.is_load ? it2_ff.taper_index : ia_full[TIDX_W-1:0];
      q_entry.en_b    = (jb >= bound2_ff.b0) && (jb < bound2_ff.b1);
      q_entry.idx_b   = ib_full[TIDX_W-1:0];
   end

   // drop samples past the trace end
   assign keep   = (it2_ff.cmd == CMD_LOAD) || (NT_W'(it2_ff.sample_index) < cfg.trace_length);
   assign q_push = v2_ff && !q_full && keep;

endmodule

`default_nettype wire

/* rtl/ttgm_queue.sv */
`default_nettype none

module ttgm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ttgm_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output ttgm_pkg::entry_type head,
   output logic                empty
);
   import ttgm_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/ttgm_back.sv */
`default_nettype none

module ttgm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  ttgm_pkg::entry_type           q_entry,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [ttgm_pkg::SAMPLE_W-1:0] rsp_gated_value,
   output logic [ttgm_pkg::SIDX_W-1:0]   rsp_gated_index
);
   import ttgm_pkg::*;

   typedef struct packed {
      sample_type        value;
      logic [SIDX_W-1:0] index;
      logic              zero;
      logic              en_a;
      logic              en_b;
   } s1_type;

   typedef struct packed {
      sample_type        value;
      logic [SIDX_W-1:0] index;
      logic              zero;
      logic              en_b;
      weight_type        w_b;
   } s2_type;

   weight_type        taper_mem [MAX_TAPER];
   weight_type        w_a_ff, w_b_ff;
   logic              v1_ff, v2_ff, v3_ff;
   logic              rdy1, rdy2, rdy3;
   s1_type            s1_ff, s1_in;
   s2_type            s2_ff, s2_in;
   sample_type        val3_ff, val3_in;
   logic [SIDX_W-1:0] idx3_ff;

   assign rdy3  = !v3_ff || rsp_pop;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   // loads retire straight into the table, samples need room in stage 1
   assign q_pop = !q_empty && (q_entry.is_load || rdy1);

   // taper table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (q_pop && q_entry.is_load) begin
         taper_mem[q_entry.idx_a] <= q_entry.weight;
      end
      if (rdy1) begin
         w_a_ff <= taper_mem[q_entry.idx_a];
         w_b_ff <= taper_mem[q_entry.idx_b];
      end
   end

   assign s1_in.value = q_entry.value;
   assign s1_in.index = q_entry.index;
   assign s1_in.zero  = q_entry.zero;
   assign s1_in.en_a  = q_entry.en_a;
   assign s1_in.en_b  = q_entry.en_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= !q_empty && !q_entry.is_load;
      end
      if (rdy1) begin
         s1_ff <= s1_in;
      end
   end

   // first taper
   assign s2_in.value = s1_ff.en_a ? taper_scale(s1_ff.value, w_a_ff) : s1_ff.value;
   assign s2_in.index = s1_ff.index;
   assign s2_in.zero  = s1_ff.zero;
   assign s2_in.en_b  = s1_ff.en_b;
   assign s2_in.w_b   = w_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
   end

   // second taper, then zeroing overrides
   always_comb begin
      if (s2_ff.zero) begin
         val3_in = '0;
      end else if (s2_ff.en_b) begin
         val3_in = taper_scale(s2_ff.value, s2_ff.w_b);
      end else begin
         val3_in = s2_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
      if (rdy3) begin
         val3_ff <= val3_in;
         idx3_ff <= s2_ff.index;
      end
   end

   assign rsp_empty       = !v3_ff;
   assign rsp_gated_value = val3_ff;
   assign rsp_gated_index = idx3_ff;

endmodule

`default_nettype wire

/* rtl/tapered_time_gate_mute_top.sv */
`default_nettype none

// channel   handshake                     payload
// req       push / full                   cmd, taper_index, taper_value, sample_value,
//                                         sample_index, mute_time, sync_time
// rsp       empty / pop                   gated_value, gated_index
// csr       psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One item per cycle sustained while rsp keeps popping. A sample passes three front
// stages (beat, base times, bounds) and the classify logic, a four-entry queue,
// then table read, first taper multiply and second taper multiply in the back.
// Load beats write the taper table when they leave the queue and give no result.
// Synchronous reset clears all valid bits and sets the CSRs to defaults; the taper
// table is not cleared. full rises only once the front stages and the queue all hold.

module tapered_time_gate_mute_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic                                  req_cmd,
   input  logic [ttgm_pkg::TIDX_W-1:0]           req_taper_index,
   input  logic [ttgm_pkg::WEIGHT_W-1:0]         req_taper_value,
   input  logic signed [ttgm_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic [ttgm_pkg::SIDX_W-1:0]           req_sample_index,
   input  logic signed [ttgm_pkg::TIME_W-1:0]    req_mute_time,
   input  logic signed [ttgm_pkg::TIME_W-1:0]    req_sync_time,
   output logic                                  empty,
   input  logic                                  pop,
   output logic signed [ttgm_pkg::SAMPLE_W-1:0]  rsp_gated_value,
   output logic [ttgm_pkg::SIDX_W-1:0]           rsp_gated_index,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ttgm_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [ttgm_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [ttgm_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);
   import ttgm_pkg::*;

   logic [MODE_W-1:0]         mode_ff;
   logic [TLEN_W-1:0]         tlen_ff, tlen_in;
   logic signed [SHIFT_W-1:0] shift_ff;
   logic [NT_W-1:0]           nt_ff, nt_in;
   logic                      csr_wr;
   logic [1:0]                reg_sel;
   cfg_type                   cfg;
   item_type                  req_item;
   entry_type                 q_in, q_head;
   logic                      q_push, q_full, q_pop, q_empty;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign reg_sel = paddr[CSR_ADDR_W-1:2];

   // clamp lengths to what the table and index widths hold
   assign tlen_in = (pwdata[TLEN_W-1:0] > TLEN_W'(MAX_TAPER)) ? TLEN_W'(MAX_TAPER)
                                                              : pwdata[TLEN_W-1:0];
   assign nt_in   = (pwdata[NT_W-1:0] > NT_W'(MAX_TRACE)) ? NT_W'(MAX_TRACE)
                                                          : pwdata[NT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ABOVE;
         tlen_ff  <= '0;
         shift_ff <= '0;
         nt_ff    <= NT_W'(MAX_TRACE);
      end else if (csr_wr) begin
         case (reg_sel)
            REG_GATE_MODE:    mode_ff  <= pwdata[MODE_W-1:0];
            REG_TAPER_LENGTH: tlen_ff  <= tlen_in;
            REG_TIME_SHIFT:   shift_ff <= pwdata[SHIFT_W-1:0];
            REG_TRACE_LENGTH: nt_ff    <= nt_in;
            default:          mode_ff  <= mode_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_GATE_MODE:    prdata = CSR_DATA_W'(mode_ff);
         REG_TAPER_LENGTH: prdata = CSR_DATA_W'(tlen_ff);
         REG_TIME_SHIFT:   prdata = CSR_DATA_W'(shift_ff);
         REG_TRACE_LENGTH: prdata = CSR_DATA_W'(nt_ff);
         default:          prdata = '0;
      endcase
   end

   assign cfg.gate_mode    = mode_ff;
   assign cfg.taper_length = tlen_ff;
   assign cfg.time_shift   = shift_ff;
   assign cfg.trace_length = nt_ff;

   assign req_item.cmd          = req_cmd;
   assign req_item.taper_index  = req_taper_index;
   assign req_item.taper_value  = req_taper_value;
   assign req_item.sample_value = req_sample_value;
   assign req_item.sample_index = req_sample_index;
   assign req_item.mute_time    = req_mute_time;
   assign req_item.sync_time    = req_sync_time;

   ttgm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .q_push   (q_push),
      .q_entry  (q_in),
      .q_full   (q_full)
   );

   ttgm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   ttgm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_entry         (q_head),
      .q_pop           (q_pop),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_gated_value (rsp_gated_value),
      .rsp_gated_index (rsp_gated_index)
   );

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("front pushed into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back popped an empty queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("block not idle after reset");

endmodule

`default_nettype wire

/* tb/ttgm_checker.sv */
`default_nettype none

module ttgm_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  logic                                 full,
   input  logic                                 req_cmd,
   input  logic [ttgm_pkg::TIDX_W-1:0]          req_taper_index,
   input  ttgm_pkg::weight_type                 req_taper_value,
   input  ttgm_pkg::sample_type                 req_sample_value,
   input  logic [ttgm_pkg::SIDX_W-1:0]          req_sample_index,
   input  logic signed [ttgm_pkg::TIME_W-1:0]   req_mute_time,
   input  logic signed [ttgm_pkg::TIME_W-1:0]   req_sync_time,
   input  logic                                 empty,
   input  logic                                 pop,
   input  ttgm_pkg::sample_type                 rsp_gated_value,
   input  logic [ttgm_pkg::SIDX_W-1:0]          rsp_gated_index,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic [ttgm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [ttgm_pkg::CSR_DATA_W-1:0]      pwdata,
   output int                                   fail_count,
   output int                                   pending
);

   timeunit 1ns;
   timeprecision 1ps;

   import ttgm_pkg::*;

   typedef struct packed {
      sample_type        value;
      logic [SIDX_W-1:0] index;
   } gated_beat_type;

   gated_beat_type    gated_q[$];
   weight_type        weight_mem[MAX_TAPER];
   logic [MODE_W-1:0] gate_mode_q;
   int                taper_len;
   int                shift_amt;
   int                trace_len;

   function automatic int max2(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int min2(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   // magnitude times weight, round half away from zero
   function automatic longint taper_mul(input longint v, input int k);
      longint mag;
      longint r;
      if (k < 0 || k >= MAX_TAPER) return v;
      mag = (v < 0) ? -v : v;
      r   = (mag * longint'(weight_mem[k]) + 64'sd32768) >>> 16;
      return (v < 0) ? -r : r;
   endfunction

   function automatic longint gated_sample(input longint v, input int j, input int t,
                                           input int s);
      int m, sh, nt, a, b, g, p0, p1, q0, q1;
      bit zero;
      m    = taper_len;
      sh   = shift_amt;
      nt   = trace_len;
      zero = 1'b0;
      case (gate_mode_q)
         MODE_ABOVE: begin
            a  = t - 2 * s - sh;
            p0 = max2(0, a - m);
            p1 = max2(0, a);
            if (j < p0) zero = 1'b1;
            else if (j < p1) v = taper_mul(v, m - 1 - (j - p0));
         end
         MODE_THETA, MODE_THETA_KEEP: begin
            if (t >= nt / 2) begin
               zero = 1'b1;
            end else begin
               g  = (gate_mode_q == MODE_THETA) ? sh : -sh;
               a  = t - 2 * s - g;
               b  = nt - t + g;
               p0 = max2(0, a);
               p1 = max2(0, a + m);
               if (j >= p0 && j < p1) v = taper_mul(v, j - p0);
               // the sample right after the leading taper stays ungated
               if (j >= p1 + 1 && j < min2(nt, b + 1 - m)) zero = 1'b1;
               q0 = min2(nt, b - m);
               q1 = min2(nt, b);
               if (j >= q0 && j < q1) v = taper_mul(v, m - 1 - (j - q0));
            end
         end
         MODE_BELOW: begin
            a  = s + t - sh;
            p0 = max2(0, a);
            p1 = max2(0, a + m);
            if (j >= p0 && j < p1) v = taper_mul(v, j - p0);
            if (j >= p1) zero = 1'b1;
         end
         MODE_PSI: begin
            a  = t - sh;
            p0 = max2(0, a - m);
            p1 = max2(0, a);
            if (j >= p0 && j < p1) v = taper_mul(v, m - 1 - (j - p0));
            if (j < max2(0, a - m - 1)) zero = 1'b1;
            if (j >= min2(nt, nt + 1 - t + sh + m)) zero = 1'b1;
            q0 = min2(nt, nt - t + sh);
            q1 = min2(nt, nt - t + sh + m);
            if (j >= q0 && j < q1) v = taper_mul(v, j - q0);
         end
         MODE_DIRECT: begin
            p0 = max2(0, t - sh - m);
            p1 = max2(0, t - sh);
            if (j < p0) zero = 1'b1;
            else if (j < p1) v = taper_mul(v, m - 1 - (j - p0));
            q0 = max2(0, t + sh);
            q1 = max2(0, t + sh + m);
            if (j >= q0 && j < q1) v = taper_mul(v, j - q0);
            if (j >= q1) zero = 1'b1;
         end
         default: ;
      endcase
      return zero ? 64'sd0 : v;
   endfunction

   always @(posedge clock) begin : watch
      gated_beat_type want;
      logic [6:0]     len_field;
      logic [12:0]    nt_field;
      if (reset) begin
         gate_mode_q = MODE_ABOVE;
         taper_len   = 0;
         shift_amt   = 0;
         trace_len   = MAX_TRACE;
         gated_q.delete();
      end else begin
         if (pop && !empty) begin
            if (gated_q.size() == 0) begin
               $error("gated beat with nothing expected: index %0d value %0d",
                      rsp_gated_index, rsp_gated_value);
               fail_count++;
            end else begin
               want = gated_q.pop_front();
               if (rsp_gated_value !== want.value) begin
                  $error("gated_value: expected %0d, got %0d", want.value, rsp_gated_value);
                  fail_count++;
               end
               if (rsp_gated_index !== want.index) begin
                  $error("gated_index: expected %0d, got %0d", want.index, rsp_gated_index);
                  fail_count++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            len_field = pwdata[6:0];
            nt_field  = pwdata[12:0];
            case (paddr[CSR_ADDR_W-1:2])
               REG_GATE_MODE:    gate_mode_q = pwdata[MODE_W-1:0];
               REG_TAPER_LENGTH: taper_len = min2(int'(len_field), MAX_TAPER);
               REG_TIME_SHIFT:   shift_amt = int'($signed(pwdata[SHIFT_W-1:0]));
               REG_TRACE_LENGTH: trace_len = min2(int'(nt_field), MAX_TRACE);
               default: ;
            endcase
         end
         if (push && !full) begin
            if (req_cmd == CMD_LOAD) begin
               weight_mem[req_taper_index] = (req_taper_value > ONE_Q16) ? ONE_Q16
                                                                         : req_taper_value;
            end else if (int'(req_sample_index) < trace_len) begin
               want.value = sample_type'(gated_sample(longint'(req_sample_value),
                                                      int'(req_sample_index),
                                                      int'(req_mute_time),
                                                      int'(req_sync_time)));
               want.index = req_sample_index;
               gated_q.push_back(want);
            end
         end
      end
      pending <= gated_q.size();
   end

endmodule

`default_nettype wire

/* tb/tb_tapered_time_gate_mute_top.sv */
`default_nettype none

module tb_tapered_time_gate_mute_top;

   timeunit 1ns;
   timeprecision 1ps;

   import ttgm_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
   localparam int                IDLE_LIMIT    = 3000;
   localparam int                SETTLE_CYCLES = 20;
   localparam int                NUM_PHASES    = 16;
   localparam int                PHASE_ITEMS   = 116;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     push = 1'b0;
   logic                     full;
   logic                     req_cmd = CMD_LOAD;
   logic [TIDX_W-1:0]        req_taper_index = '0;
   weight_type               req_taper_value = '0;
   sample_type               req_sample_value = '0;
   logic [SIDX_W-1:0]        req_sample_index = '0;
   logic signed [TIME_W-1:0] req_mute_time = '0;
   logic signed [TIME_W-1:0] req_sync_time = '0;
   logic                     empty;
   logic                     pop = 1'b0;
   sample_type               rsp_gated_value;
   logic [SIDX_W-1:0]        rsp_gated_index;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    paddr = '0;
   logic [CSR_DATA_W-1:0]    pwdata = '0;
   logic [CSR_DATA_W-1:0]    prdata;
   logic                     pready;

   int gated_pending;
   int fail_total;
   bit steady = 1'b0;
   int m_cfg;
   int sh_cfg;
   int nt_cfg;

   // per-phase settings: mode, taper length, shift, trace length
   logic [MODE_W-1:0] phase_mode[NUM_PHASES] = '{
      MODE_ABOVE, MODE_THETA, MODE_THETA_KEEP, MODE_BELOW, MODE_PSI, MODE_DIRECT,
      MODE_SPARE_LO, MODE_SPARE_HI, MODE_ABOVE, MODE_THETA, MODE_THETA_KEEP, MODE_DIRECT,
      MODE_BELOW, MODE_PSI, MODE_DIRECT, MODE_ABOVE};
   int phase_taper[NUM_PHASES] = '{8, 16, 64, 127, 0, 33, 10, 5, 1, 64, 3, 12, 20, 64, 64, 0};
   int phase_shift[NUM_PHASES] = '{0, 5, -30, 8191, -8192, 40, 0, -1, -100, 4096, -4096, 0,
                                   3, 7, -7, 0};
   int phase_nt[NUM_PHASES] = '{64, 200, 300, 8191, 1, 500, 100, 37, 128, 4096, 2, 0,
                                1000, 256, 4096, 1};

   tapered_time_gate_mute_top u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_taper_index  (req_taper_index),
      .req_taper_value  (req_taper_value),
      .req_sample_value (req_sample_value),
      .req_sample_index (req_sample_index),
      .req_mute_time    (req_mute_time),
      .req_sync_time    (req_sync_time),
      .empty            (empty),
      .pop              (pop),
      .rsp_gated_value  (rsp_gated_value),
      .rsp_gated_index  (rsp_gated_index),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   ttgm_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_taper_index  (req_taper_index),
      .req_taper_value  (req_taper_value),
      .req_sample_value (req_sample_value),
      .req_sample_index (req_sample_index),
      .req_mute_time    (req_mute_time),
      .req_sync_time    (req_sync_time),
      .empty            (empty),
      .pop              (pop),
      .rsp_gated_value  (rsp_gated_value),
      .rsp_gated_index  (rsp_gated_index),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .fail_count       (fail_total),
      .pending          (gated_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty) || (psel && penable && pready)) idle = 0;
         else idle++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random runs of pop high and low, always high in steady phases
   initial begin : drain_side
      int n;
      forever begin
         @(negedge clock);
         if (steady || $urandom_range(0, 99) < 60) begin
            pop <= 1'b1;
            n = $urandom_range(1, 8);
         end else begin
            pop <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
         end
         repeat (n - 1) @(negedge clock);
      end
   end

   function automatic weight_type pick_weight();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ONE_Q16;
         2:       return '1;
         3:       return weight_type'($urandom_range(65537, 131071));
         default: return weight_type'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 19))
         0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
         1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic sender_gap();
      int n;
      int r;
      n = 0;
      if (!steady) begin
         r = $urandom_range(0, 99);
         if (r >= 93) n = $urandom_range(10, 40);
         else if (r >= 55) n = $urandom_range(1, 3);
      end
      if (n > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic put_beat(input logic cmd, input logic [TIDX_W-1:0] tidx,
                           input weight_type tval, input sample_type sval,
                           input int sidx, input int mute, input int sync);
      @(negedge clock);
      push             <= 1'b1;
      req_cmd          <= cmd;
      req_taper_index  <= tidx;
      req_taper_value  <= tval;
      req_sample_value <= sval;
      req_sample_index <= SIDX_W'(sidx);
      req_mute_time    <= TIME_W'(mute);
      req_sync_time    <= TIME_W'(sync);
      do @(posedge clock); while (full);
      sender_gap();
   endtask

   task automatic put_load(input int tidx, input weight_type tval);
      put_beat(CMD_LOAD, TIDX_W'(tidx), tval, pick_sample(), $urandom_range(0, 4095),
               $urandom_range(0, 16383), $urandom_range(0, 16383));
   endtask

   task automatic put_sample(input sample_type sval, input int sidx, input int mute,
                             input int sync);
      put_beat(CMD_SAMPLE, TIDX_W'($urandom), weight_type'($urandom), sval, sidx, mute,
               sync);
   endtask

   // hold the sender until every expected beat is back
   task automatic hold_until_drained();
      @(negedge clock);
      push <= 1'b0;
      while (gated_pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_gate(input logic [MODE_W-1:0] mode, input int m, input int sh,
                             input int nt);
      hold_until_drained();
      // let out-of-trace samples and loads clear the pipeline
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(REG_GATE_MODE, CSR_DATA_W'(mode));
      write_reg(REG_TAPER_LENGTH, CSR_DATA_W'(m));
      write_reg(REG_TIME_SHIFT, CSR_DATA_W'(sh));
      write_reg(REG_TRACE_LENGTH, CSR_DATA_W'(nt));
      m_cfg  = (m > MAX_TAPER) ? MAX_TAPER : m;
      sh_cfg = int'($signed(SHIFT_W'(sh)));
      nt_cfg = (nt > MAX_TRACE) ? MAX_TRACE : nt;
   endtask

   task automatic directed_items();
      // mode above, taper 8, trace 64: zero below 8, taper [8,16), pass from 16
      put_load(63, '1);
      put_load(0, '0);
      put_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 0, 20, 2);
      put_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 8, 20, 2);
      put_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 15, 20, 2);
      put_sample('1, 12, 20, 2);
      put_sample(sample_type'(12345), 16, 20, 2);
      put_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 63, 20, 2);
      put_sample(sample_type'(77), 64, 20, 2);
      put_sample(sample_type'(-77), 4095, 20, 2);
      put_sample(sample_type'(-999), 5, -8192, 8191);
      put_sample(sample_type'(999), 40, 8191, -8192);
      put_load(7, ONE_Q16);
      put_sample(sample_type'(-4242), 8, 20, 2);
      put_load(7, weight_type'(32768));
      put_sample(sample_type'(3), 8, 20, 2);
      put_sample(sample_type'(-3), 8, 20, 2);
      put_load(6, weight_type'(98304));
      put_sample(sample_type'(-5), 9, 20, 2);
      put_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 9, 20, 2);
   endtask

   task automatic random_items(input int count, input bit with_hold);
      int i, t, s, left, anchor, j, span, nt;
      t    = 0;
      s    = 0;
      left = 0;
      nt   = (nt_cfg == 0) ? 64 : nt_cfg;
      for (i = 0; i < count; i++) begin
         if (with_hold && i == count / 2) hold_until_drained();
         if (left == 0) begin
            left = $urandom_range(4, 24);
            if ($urandom_range(0, 11) == 0) begin
               t = int'($urandom_range(0, 16383)) - 8192;
               s = int'($urandom_range(0, 16383)) - 8192;
            end else begin
               t = int'($urandom_range(0, nt + nt / 4)) - nt / 8;
               s = int'($urandom_range(0, nt / 4)) - nt / 8;
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            put_load($urandom_range(0, MAX_TAPER - 1), pick_weight());
         end else begin
            // aim at gate edges so the tapers and boundaries get exercised
            case ($urandom_range(0, 9))
               0:       anchor = t - 2 * s - sh_cfg;
               1:       anchor = t - 2 * s + sh_cfg;
               2:       anchor = nt - t + sh_cfg;
               3:       anchor = nt - t - sh_cfg;
               4:       anchor = s + t - sh_cfg;
               5:       anchor = t - sh_cfg;
               6:       anchor = t + sh_cfg;
               7:       anchor = nt + 1 - t + sh_cfg + m_cfg;
               8:       anchor = 0;
               default: anchor = $urandom_range(0, nt - 1);
            endcase
            span = m_cfg + 3;
            j = anchor + int'($urandom_range(0, 2 * span)) - span;
            if (j < 0) j = 0;
            if (j > nt - 1) j = nt - 1;
            if ($urandom_range(0, 19) == 0) j = $urandom_range(0, 4095);
            put_sample(pick_sample(), j, t, s);
            left--;
         end
      end
   endtask

   initial begin : stimulus
      int k, p;
      m_cfg  = 0;
      sh_cfg = 0;
      nt_cfg = MAX_TRACE;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // every taper entry gets written before any sample can read it
      for (k = 0; k < MAX_TAPER; k++) put_load(k, pick_weight());
      for (p = 0; p < NUM_PHASES; p++) begin
         steady = 1'b0;
         if (p == NUM_PHASES - 1) begin
            apply_gate(MODE_W'($urandom_range(0, 7)), $urandom_range(0, 80),
                       int'($urandom_range(0, 200)) - 100, $urandom_range(1, 600));
         end else begin
            apply_gate(phase_mode[p], phase_taper[p], phase_shift[p], phase_nt[p]);
         end
         steady = (p % 4 == 3);
         if (p == 0) directed_items();
         random_items(PHASE_ITEMS, p == 2);
      end
      steady = 1'b0;
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_total == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* tapered_time_gate_mute_top.f */
rtl/ttgm_pkg.sv
rtl/ttgm_front.sv
rtl/ttgm_queue.sv
rtl/ttgm_back.sv
rtl/tapered_time_gate_mute_top.sv
tb/ttgm_checker.sv
tb/tb_tapered_time_gate_mute_top.sv
